>>> src/fr_pkg.sv
package fr_pkg;

    // cordic iteration count, one pipeline stage each
    localparam int CORDIC_ITERATIONS = 16;

    localparam logic [15:0] ANGLE_MAX   = 16'd51472;
    localparam logic [33:0] CORDIC_GAIN = 34'd652032874;
    localparam logic [30:0] ONE_Q30     = 31'h4000_0000;
    localparam logic [16:0] ONE_Q16     = 17'h1_0000;

    // arctangent of 2^-i in unsigned Q0.30
    localparam logic [29:0] ATAN_Q30 [0:31] = '{
        30'd843314857, 30'd497837829, 30'd263043837, 30'd133525159,
        30'd67021687,  30'd33543516,  30'd16775851,  30'd8388437,
        30'd4194283,   30'd2097149,   30'd1048576,   30'd524288,
        30'd262144,    30'd131072,    30'd65536,     30'd32768,
        30'd16384,     30'd8192,      30'd4096,      30'd2048,
        30'd1024,      30'd512,       30'd256,       30'd128,
        30'd64,        30'd32,        30'd16,        30'd8,
        30'd4,         30'd2,         30'd1,         30'd0
    };

    // request fields carried alongside the math
    typedef struct packed {
        logic [15:0] n1;
        logic [15:0] n2;
        logic        spol;
    } t_side;

    typedef struct packed {
        t_side       side;
        logic        tir;
        logic [30:0] cos_i;
    } t_mid;

endpackage

>>> src/fr_in_if.sv
interface fr_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] index_from;
    logic [15:0] index_to;
    logic [15:0] incidence_angle;
    logic        s_polarized;

    modport source(output valid, output index_from, output index_to,
                   output incidence_angle, output s_polarized, input ready);
    modport sink(input valid, input index_from, input index_to,
                 input incidence_angle, input s_polarized, output ready);
endinterface

>>> src/fr_out_if.sv
interface fr_out_if;
    logic        valid;
    logic        ready;
    logic [16:0] reflectance;
    logic        total_internal;

    modport source(output valid, output reflectance, output total_internal, input ready);
    modport sink(input valid, input reflectance, input total_internal, output ready);
endinterface

>>> src/fresnel_reflectance_top.sv
// throughput: one request per cycle; every stage is a register with its own valid bit
// the depth is set by the cordic stages, two bit-per-stage dividers and the root stages
// a stalled output holds the whole pipeline; no bubbles are lost or repeated
// reset: synchronous active-low, clears all valid bits; data registers are not reset
module fresnel_reflectance_top (
    input  logic     i_clk,
    input  logic     i_rst_n,
    fr_in_if.sink    i_req,
    fr_out_if.source o_rsp
);
    localparam int D1 = 31;
    localparam int D2 = 32;

    logic en;
    logic r_out_v;

    // global advance: move when the output slot is free or being taken
    assign en          = !r_out_v || o_rsp.ready;
    assign i_req.ready = en;

    // sin and cos of the incidence angle
    fr_pkg::t_side in_side;
    logic          c_v;
    fr_pkg::t_side c_side;
    logic [30:0]   c_cos;
    logic [30:0]   c_sin;

    assign in_side.n1   = i_req.index_from;
    assign in_side.n2   = i_req.index_to;
    assign in_side.spol = i_req.s_polarized;

    fr_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_req.valid && i_req.ready),
        .i_side  (in_side),
        .i_angle (i_req.incidence_angle),
        .o_valid (c_v),
        .o_side  (c_side),
        .o_cos   (c_cos),
        .o_sin   (c_sin)
    );

    // n1 * sin
    logic          r_l_v;
    fr_pkg::t_mid  r_l_mid;
    logic [45:0]   r_l_lhs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_l_v <= 1'b0;
        end else if (en) begin
            r_l_v <= c_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_l_mid.side  <= c_side;
            r_l_mid.tir   <= 1'b0;
            r_l_mid.cos_i <= c_cos;
            r_l_lhs       <= 46'(c_side.n1 * c_sin);
        end
    end

    // total internal check and divider load
    logic         r_d1_v   [0:D1];
    fr_pkg::t_mid r_d1_mid [0:D1];
    logic [46:0]  r_d1_rem [0:D1];
    logic [30:0]  r_d1_q   [0:D1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d1_v[0] <= 1'b0;
        end else if (en) begin
            r_d1_v[0] <= r_l_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d1_mid[0].side  <= r_l_mid.side;
            r_d1_mid[0].cos_i <= r_l_mid.cos_i;
            r_d1_mid[0].tir   <= r_l_lhs > {r_l_mid.side.n2, 30'd0};
            r_d1_rem[0]       <= {1'b0, r_l_lhs};
            r_d1_q[0]         <= '0;
        end
    end

    // s = n1 * sin / n2, one quotient bit per stage
    for (genvar gi = 0; gi < D1; gi++) begin : g_d1
        localparam int K = D1 - 1 - gi;
        logic [46:0] dv;
        logic        ge;

        assign dv = {31'd0, r_d1_mid[gi].side.n2} << K;
        assign ge = r_d1_rem[gi] >= dv;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_d1_v[gi+1] <= 1'b0;
            end else if (en) begin
                r_d1_v[gi+1] <= r_d1_v[gi];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_d1_mid[gi+1] <= r_d1_mid[gi];
                r_d1_rem[gi+1] <= ge ? r_d1_rem[gi] - dv : r_d1_rem[gi];
                r_d1_q[gi+1]   <= ge ? (r_d1_q[gi] | (31'd1 << K)) : r_d1_q[gi];
            end
        end
    end

    // s with zero n2 taken as zero
    logic         r_s_v;
    fr_pkg::t_mid r_s_mid;
    logic [30:0]  r_s;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s_v <= 1'b0;
        end else if (en) begin
            r_s_v <= r_d1_v[D1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s_mid <= r_d1_mid[D1];
            r_s     <= (r_d1_mid[D1].side.n2 == '0) ? '0 : r_d1_q[D1];
        end
    end

    // s squared
    logic         r_sq_v;
    fr_pkg::t_mid r_sq_mid;
    logic [61:0]  r_sq;
    logic [60:0]  det;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_v <= 1'b0;
        end else if (en) begin
            r_sq_v <= r_s_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sq_mid <= r_s_mid;
            r_sq     <= r_s * r_s;
        end
    end

    assign det = (61'(1) << 60) - r_sq[60:0];

    // cos_t = sqrt(1 - s^2)
    logic         rt_v;
    fr_pkg::t_mid rt_mid;
    logic [30:0]  cos_t;

    fr_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_sq_v),
        .i_mid   (r_sq_mid),
        .i_det   (det),
        .o_valid (rt_v),
        .o_mid   (rt_mid),
        .o_root  (cos_t)
    );

    // polarization terms a and b
    logic        r_p_v;
    logic        r_p_tir;
    logic [46:0] r_p_a;
    logic [46:0] r_p_b;
    logic [30:0] ca;
    logic [30:0] cb;

    assign ca = rt_mid.side.spol ? rt_mid.cos_i : cos_t;
    assign cb = rt_mid.side.spol ? cos_t : rt_mid.cos_i;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_v <= 1'b0;
        end else if (en) begin
            r_p_v <= rt_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p_tir <= rt_mid.tir;
            r_p_a   <= 47'(rt_mid.side.n1 * ca);
            r_p_b   <= 47'(rt_mid.side.n2 * cb);
        end
    end

    // numerator magnitude and denominator
    logic        r_n_v;
    logic        r_n_tir;
    logic [47:0] r_n_num;
    logic [47:0] r_n_den;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n_v <= 1'b0;
        end else if (en) begin
            r_n_v <= r_p_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_n_tir <= r_p_tir;
            r_n_num <= (r_p_a > r_p_b) ? {1'b0, r_p_a - r_p_b} : {1'b0, r_p_b - r_p_a};
            r_n_den <= {1'b0, r_p_a} + {1'b0, r_p_b};
        end
    end

    // scale denominator below 2^32 and load the ratio divider
    logic [4:0]  sh;
    logic [47:0] num_sh;
    logic [47:0] den_sh;

    always_comb begin
        sh = '0;
        for (int k = 32; k < 48; k++) begin
            if (r_n_den[k]) sh = 5'(k - 31);
        end
    end

    assign num_sh = r_n_num >> sh;
    assign den_sh = r_n_den >> sh;

    logic        r_d2_v    [0:D2];
    logic        r_d2_tir  [0:D2];
    logic        r_d2_zero [0:D2];
    logic [31:0] r_d2_den  [0:D2];
    logic [32:0] r_d2_rem  [0:D2];
    logic [31:0] r_d2_q    [0:D2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d2_v[0] <= 1'b0;
        end else if (en) begin
            r_d2_v[0] <= r_n_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d2_tir[0]  <= r_n_tir;
            r_d2_zero[0] <= r_n_den == '0;
            r_d2_den[0]  <= den_sh[31:0];
            r_d2_rem[0]  <= num_sh[32:0];
            r_d2_q[0]    <= '0;
        end
    end

    // q = num * 2^31 / den, one quotient bit per stage
    for (genvar gi = 0; gi < D2; gi++) begin : g_d2
        logic [32:0] tr;
        logic        ge;

        if (gi == 0) begin : g_first
            assign tr = r_d2_rem[gi];
        end else begin : g_next
            assign tr = r_d2_rem[gi] << 1;
        end

        assign ge = tr >= {1'b0, r_d2_den[gi]};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_d2_v[gi+1] <= 1'b0;
            end else if (en) begin
                r_d2_v[gi+1] <= r_d2_v[gi];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_d2_tir[gi+1]  <= r_d2_tir[gi];
                r_d2_zero[gi+1] <= r_d2_zero[gi];
                r_d2_den[gi+1]  <= r_d2_den[gi];
                r_d2_rem[gi+1]  <= ge ? tr - {1'b0, r_d2_den[gi]} : tr;
                r_d2_q[gi+1]    <= {r_d2_q[gi][30:0], ge};
            end
        end
    end

    // q squared
    logic        r_m_v;
    logic        r_m_tir;
    logic        r_m_zero;
    logic [63:0] r_m_qq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_v <= 1'b0;
        end else if (en) begin
            r_m_v <= r_d2_v[D2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_m_tir  <= r_d2_tir[D2];
            r_m_zero <= r_d2_zero[D2];
            r_m_qq   <= r_d2_q[D2] * r_d2_q[D2];
        end
    end

    // round to Q1.16, saturate, output register
    logic [63:0] rsum;
    logic [17:0] rnd;
    logic [16:0] sat;
    logic [16:0] r_refl;
    logic        r_tir;

    assign rsum = r_m_qq + (64'(1) << 45);
    assign rnd  = rsum[63:46];
    assign sat  = (rnd > {1'b0, fr_pkg::ONE_Q16}) ? fr_pkg::ONE_Q16 : rnd[16:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (en) begin
            r_out_v <= r_m_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_tir  <= r_m_tir;
            r_refl <= (r_m_tir || r_m_zero) ? fr_pkg::ONE_Q16 : sat;
        end
    end

    assign o_rsp.valid          = r_out_v;
    assign o_rsp.reflectance    = r_refl;
    assign o_rsp.total_internal = r_tir;

`ifndef SYNTHESIS
    a_tir_is_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && o_rsp.total_internal |-> o_rsp.reflectance == fr_pkg::ONE_Q16)
        else $error("total internal reflection without full reflectance");

    a_refl_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> o_rsp.reflectance <= fr_pkg::ONE_Q16)
        else $error("reflectance above one");

    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_rsp.valid |-> i_req.ready)
        else $error("input stalled with empty output slot");

    a_hold_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_req.ready |=> $stable(r_m_v) && $stable(r_d2_v[D2]))
        else $error("pipeline moved during a stall");
`endif

endmodule

>>> src/fr_cordic.sv
module fr_cordic (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  fr_pkg::t_side i_side,
    input  logic [15:0]   i_angle,
    output logic          o_valid,
    output fr_pkg::t_side o_side,
    output logic [30:0]   o_cos,
    output logic [30:0]   o_sin
);
    localparam int N = fr_pkg::CORDIC_ITERATIONS;

    logic signed [33:0] r_x [0:N];
    logic signed [33:0] r_y [0:N];
    logic signed [32:0] r_z [0:N];
    logic               r_v [0:N];
    fr_pkg::t_side      r_s [0:N];
    logic [15:0]        ang_c;

    function automatic logic [30:0] clamp_unit(input logic signed [33:0] v);
        if (v < 0) return '0;
        if (v > $signed({3'b000, fr_pkg::ONE_Q30})) return fr_pkg::ONE_Q30;
        return v[30:0];
    endfunction

    // angle clamp and load
    assign ang_c = (i_angle > fr_pkg::ANGLE_MAX) ? fr_pkg::ANGLE_MAX : i_angle;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0] <= $signed(fr_pkg::CORDIC_GAIN);
            r_y[0] <= '0;
            r_z[0] <= $signed({2'b00, ang_c, 15'd0});
            r_s[0] <= i_side;
        end
    end

    // one rotation per stage
    for (genvar gi = 0; gi < N; gi++) begin : g_it
        logic signed [33:0] dx;
        logic signed [33:0] dy;
        logic signed [32:0] at;

        assign dx = r_y[gi] >>> gi;
        assign dy = r_x[gi] >>> gi;
        assign at = $signed({3'b000, fr_pkg::ATAN_Q30[gi]});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[gi+1] <= 1'b0;
            end else if (i_en) begin
                r_v[gi+1] <= r_v[gi];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_s[gi+1] <= r_s[gi];
                if (r_z[gi] >= 0) begin
                    r_x[gi+1] <= r_x[gi] - dx;
                    r_y[gi+1] <= r_y[gi] + dy;
                    r_z[gi+1] <= r_z[gi] - at;
                end else begin
                    r_x[gi+1] <= r_x[gi] + dx;
                    r_y[gi+1] <= r_y[gi] - dy;
                    r_z[gi+1] <= r_z[gi] + at;
                end
            end
        end
    end

    // clamp to the unit range
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= r_v[N];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_side <= r_s[N];
            o_cos  <= clamp_unit(r_x[N]);
            o_sin  <= clamp_unit(r_y[N]);
        end
    end

endmodule

>>> src/fr_isqrt.sv
module fr_isqrt (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_en,
    input  logic         i_valid,
    input  fr_pkg::t_mid i_mid,
    input  logic [60:0]  i_det,
    output logic         o_valid,
    output fr_pkg::t_mid o_mid,
    output logic [30:0]  o_root
);
    localparam int STEPS = 31;

    logic [60:0]  r_rem [0:STEPS];
    logic [62:0]  r_res [0:STEPS];
    logic         r_v   [0:STEPS];
    fr_pkg::t_mid r_m   [0:STEPS];

    // load
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= i_det;
            r_res[0] <= '0;
            r_m[0]   <= i_mid;
        end
    end

    // one result bit per stage, trial bit 2^(60-2j)
    for (genvar gi = 0; gi < STEPS; gi++) begin : g_st
        localparam logic [62:0] B = 63'(1) << (60 - 2 * gi);
        logic [62:0] sum;
        logic        ge;

        assign sum = r_res[gi] + B;
        assign ge  = {2'b00, r_rem[gi]} >= sum;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[gi+1] <= 1'b0;
            end else if (i_en) begin
                r_v[gi+1] <= r_v[gi];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_m[gi+1] <= r_m[gi];
                if (ge) begin
                    r_rem[gi+1] <= r_rem[gi] - sum[60:0];
                    r_res[gi+1] <= (r_res[gi] >> 1) + B;
                end else begin
                    r_rem[gi+1] <= r_rem[gi];
                    r_res[gi+1] <= r_res[gi] >> 1;
                end
            end
        end
    end

    assign o_valid = r_v[STEPS];
    assign o_mid   = r_m[STEPS];
    assign o_root  = r_res[STEPS][30:0];

endmodule

>>> bench/fresnel_reflectance_top_test.sv
module fresnel_reflectance_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [15:0] n1;
        logic [15:0] n2;
        logic [15:0] ang;
        logic        spol;
    } t_request;

    typedef struct {
        logic [16:0] refl;
        logic        tir;
    } t_reflect;

    // directed row: request plus an optional hand-typed answer
    typedef struct {
        t_request req;
        logic     typed;
        t_reflect want;
    } t_row;

    localparam int RANDOM_REQUESTS = 1650;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    fr_in_if  req_if();
    fr_out_if rsp_if();

    fresnel_reflectance_top dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_if.sink),
        .o_rsp  (rsp_if.source)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    t_reflect pending_reflect[$];
    int       mismatch_count = 0;
    int       sent_count = 0;
    int       got_count = 0;
    int       tir_count = 0;
    logic     stim_done = 1'b0;

    // floor shift of a signed value
    function automatic longint fshift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint unsigned root_floor(longint unsigned v);
        longint unsigned acc;
        longint unsigned bitv;
        acc = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= acc + bitv) begin
                v -= acc + bitv;
                acc = (acc >> 1) + bitv;
            end else begin
                acc >>= 1;
            end
            bitv >>= 2;
        end
        return acc;
    endfunction

    function automatic logic [16:0] power_ratio(longint unsigned a, longint unsigned b);
        longint unsigned num;
        longint unsigned den;
        longint unsigned q;
        longint unsigned r;
        num = (a > b) ? a - b : b - a;
        den = a + b;
        if (den == 0) return fr_pkg::ONE_Q16;
        while (den >= (64'd1 << 32)) begin
            den >>= 1;
            num >>= 1;
        end
        if (den == 0) return fr_pkg::ONE_Q16;
        q = (num << 31) / den;
        if (q > (64'd1 << 31)) q = 64'd1 << 31;
        r = (q * q + (64'd1 << 45)) >> 46;
        if (r > fr_pkg::ONE_Q16) r = fr_pkg::ONE_Q16;
        return r[16:0];
    endfunction

    // fresnel reflectance of one surface hit
    function automatic t_reflect fresnel_predict(t_request rq);
        t_reflect res;
        longint          x;
        longint          y;
        longint          z;
        longint          dx;
        longint          dy;
        longint unsigned a;
        longint unsigned n1;
        longint unsigned n2;
        longint unsigned sin_i;
        longint unsigned cos_i;
        longint unsigned lhs;
        longint unsigned s;
        longint unsigned cos_t;
        n1 = rq.n1;
        n2 = rq.n2;
        a = (rq.ang > fr_pkg::ANGLE_MAX) ? fr_pkg::ANGLE_MAX : rq.ang;
        x = fr_pkg::CORDIC_GAIN;
        y = 0;
        z = a << 15;
        for (int i = 0; i < fr_pkg::CORDIC_ITERATIONS && i < 32; i++) begin
            dx = fshift(y, i);
            dy = fshift(x, i);
            if (z >= 0) begin
                x -= dx; y += dy; z -= longint'(fr_pkg::ATAN_Q30[i]);
            end else begin
                x += dx; y -= dy; z += longint'(fr_pkg::ATAN_Q30[i]);
            end
        end
        cos_i = (x < 0) ? 0 : (x > fr_pkg::ONE_Q30) ? fr_pkg::ONE_Q30 : x;
        sin_i = (y < 0) ? 0 : (y > fr_pkg::ONE_Q30) ? fr_pkg::ONE_Q30 : y;
        lhs = n1 * sin_i;
        if (lhs > (n2 << 30)) begin
            res.refl = fr_pkg::ONE_Q16;
            res.tir = 1'b1;
            return res;
        end
        s = (n2 == 0) ? 0 : lhs / n2;
        if (s > fr_pkg::ONE_Q30) s = fr_pkg::ONE_Q30;
        cos_t = root_floor((64'd1 << 60) - s * s);
        if (rq.spol) res.refl = power_ratio(n1 * cos_i, n2 * cos_t);
        else res.refl = power_ratio(n1 * cos_t, n2 * cos_i);
        res.tir = 1'b0;
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [16:0] got, logic [16:0] want);
        mismatch_count++;
        $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
    endtask

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    function automatic t_row mk(int n1, int n2, int ang, int sp, int typed, int refl, int tir);
        t_row r;
        r.req.n1 = 16'(n1);
        r.req.n2 = 16'(n2);
        r.req.ang = 16'(ang);
        r.req.spol = 1'(sp);
        r.typed = 1'(typed);
        r.want.refl = 17'(refl);
        r.want.tir = 1'(tir);
        return r;
    endfunction

    task automatic send_request(t_request rq, logic typed, t_reflect want);
        t_reflect exp_r;
        exp_r = fresnel_predict(rq);
        if (typed && (exp_r.refl !== want.refl || exp_r.tir !== want.tir))
            report_mismatch("typed row vs predictor", exp_r.refl, want.refl);
        if (typed) exp_r = want;
        req_if.index_from <= rq.n1;
        req_if.index_to <= rq.n2;
        req_if.incidence_angle <= rq.ang;
        req_if.s_polarized <= rq.spol;
        req_if.valid <= 1'b1;
        do @(posedge i_clk); while (!req_if.ready);
        pending_reflect = {pending_reflect, exp_r};
        sent_count++;
        @(negedge i_clk);
    endtask

    // random request: mostly in-range, some out-of-range angles and zero indices
    function automatic t_request rand_request();
        t_request rq;
        int k;
        k = $urandom_range(0, 19);
        rq.n1 = (k == 0) ? 16'($urandom_range(0, 16383)) : 16'($urandom_range(16384, 65535));
        rq.n2 = (k == 1) ? 16'd0 : (k == 2) ? rq.n1 : 16'($urandom_range(16384, 65535));
        rq.ang = (k == 3) ? 16'($urandom_range(51473, 65535)) : 16'($urandom_range(0, 51472));
        rq.spol = 1'($urandom_range(0, 1));
        return rq;
    endfunction

    // request side
    initial begin
        t_row rows[$];
        int   g;
        req_if.valid = 1'b0;
        req_if.index_from = '0;
        req_if.index_to = '0;
        req_if.incidence_angle = '0;
        req_if.s_polarized = 1'b0;
        rows = {rows, mk(16384, 16384, 0, 1, 0, 0, 0)};
        rows = {rows, mk(16384, 16384, 0, 0, 0, 0, 0)};
        rows = {rows, mk(65535, 16384, 51472, 1, 1, 65536, 1)};
        rows = {rows, mk(65535, 16384, 51472, 0, 1, 65536, 1)};
        rows = {rows, mk(65535, 16384, 65535, 1, 1, 65536, 1)};
        rows = {rows, mk(16384, 0, 20000, 0, 1, 65536, 1)};
        rows = {rows, mk(16384, 0, 0, 1, 0, 0, 0)};
        rows = {rows, mk(0, 0, 0, 1, 1, 65536, 0)};
        rows = {rows, mk(0, 0, 30000, 0, 1, 65536, 0)};
        rows = {rows, mk(16384, 65535, 0, 1, 0, 0, 0)};
        rows = {rows, mk(65535, 16384, 0, 0, 0, 0, 0)};
        rows = {rows, mk(16384, 65535, 51472, 1, 0, 0, 0)};
        rows = {rows, mk(16384, 65535, 51472, 0, 0, 0, 0)};
        rows = {rows, mk(16384, 16384, 51472, 1, 0, 0, 0)};
        rows = {rows, mk(16384, 16384, 51472, 0, 0, 0, 0)};
        rows = {rows, mk(32768, 16384, 17157, 1, 0, 0, 0)};
        rows = {rows, mk(32768, 16384, 17157, 0, 0, 0, 0)};
        rows = {rows, mk(24576, 16384, 30000, 0, 0, 0, 0)};
        rows = {rows, mk(16384, 24576, 30000, 1, 0, 0, 0)};
        rows = {rows, mk(43690, 21845, 40000, 1, 0, 0, 0)};
        rows = {rows, mk(65535, 65535, 65535, 1, 0, 0, 0)};
        rows = {rows, mk(21845, 43690, 25000, 0, 0, 0, 0)};
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        foreach (rows[i]) begin
            send_request(rows[i].req, rows[i].typed, rows[i].want);
            g = (i % 3 == 0) ? 0 : gap_len();
            if (g > 0) begin
                req_if.valid <= 1'b0;
                repeat (g) @(negedge i_clk);
            end
        end
        for (int i = 0; i < RANDOM_REQUESTS; i++) begin
            send_request(rand_request(), 1'b0, '{17'd0, 1'b0});
            // stretches of back-to-back requests between gapped ones
            g = ((i / 200) % 2 == 1) ? 0 : gap_len();
            if (g > 0) begin
                req_if.valid <= 1'b0;
                repeat (g) @(negedge i_clk);
            end
        end
        req_if.valid <= 1'b0;
        stim_done = 1'b1;
    end

    // response side: stall at random, check on accept
    initial begin
        int s;
        rsp_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            s = ((got_count / 300) % 2 == 1) ? 0 : gap_len();
            rsp_if.ready <= (s == 0);
        end
    end

    always @(posedge i_clk) begin
        t_reflect want;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            got_count++;
            if (pending_reflect.size() == 0) begin
                report_mismatch("unexpected response", rsp_if.reflectance, 17'd0);
            end else begin
                want = pending_reflect.pop_front();
                if (rsp_if.reflectance !== want.refl)
                    report_mismatch("reflectance", rsp_if.reflectance, want.refl);
                if (rsp_if.total_internal !== want.tir)
                    report_mismatch("total_internal", {16'd0, rsp_if.total_internal},
                                    {16'd0, want.tir});
                if (want.tir) tir_count++;
            end
        end
    end

    // end of run
    initial begin
        wait (stim_done);
        while (pending_reflect.size() != 0) @(posedge i_clk);
        repeat (fr_pkg::CORDIC_ITERATIONS + 150) @(posedge i_clk);
        $display("covered %0d requests, %0d responses, %0d total internal reflections",
                 sent_count, got_count, tir_count);
        if (mismatch_count == 0 && pending_reflect.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #10ms;
        $display("timeout with %0d responses outstanding", pending_reflect.size());
        $display("Regression FAIL");
        $finish;
    end

endmodule

>>> sim.f
src/fr_pkg.sv
src/fr_in_if.sv
src/fr_out_if.sv
src/fr_cordic.sv
src/fr_isqrt.sv
src/fresnel_reflectance_top.sv
bench/fresnel_reflectance_top_test.sv
